// File: hw/rtl/height_to_grayscale_normalizer_core_defines.svh
// Assertion macros shared by the checker of the gray level normalizer.
// Depends on nothing; included by name where assertions are written.
`ifndef HEIGHT_TO_GRAYSCALE_NORMALIZER_CORE_DEFINES_SVH
`define HEIGHT_TO_GRAYSCALE_NORMALIZER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTGN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htgn: same cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HTGN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htgn: next cycle check failed");

`endif

// File: hw/rtl/htgn_pkg.sv
// Types and constants of the height to gray level normalizer.
// Used by the front, back, top level and checker; depends on nothing.
package htgn_pkg;

  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_MEASURE = 2'd1;
  localparam logic [1:0] OP_COLOUR  = 2'd2;

  localparam logic [7:0] GRAY_BASE = 8'd25;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_COLOUR  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] height;
  } in_item_t;

  typedef struct packed {
    logic [7:0] gray;
    logic       flat_or_empty;
    logic       clamped;
  } out_item_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] height;
  } q_entry_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

// File: hw/rtl/htgn_front.sv
// Front part: accepts input items, classifies the op and queues commands.
// Depends on htgn_pkg.
module htgn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  htgn_pkg::in_item_t in_item_i,
  output logic              head_valid_o,
  output htgn_pkg::q_entry_t head_o,
  input  logic              pop_i
);
  import htgn_pkg::*;

  q_entry_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       accept, push, pop;
  q_entry_t   entry;

  assign in_stall_o = (count_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;

  // Unused op codes are dropped here and never reach the back part.
  always_comb begin
    push       = 1'b0;
    entry.cmd  = CMD_MEASURE;
    entry.height = in_item_i.height;
    unique case (in_item_i.op)
      OP_RESTART: begin
        push      = accept;
        entry.cmd = CMD_RESTART;
      end
      OP_MEASURE: begin
        push      = accept;
        entry.cmd = CMD_MEASURE;
      end
      OP_COLOUR: begin
        push      = accept;
        entry.cmd = CMD_COLOUR;
      end
      default: push = 1'b0;
    endcase
  end

  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// File: hw/rtl/htgn_back.sv
// Back part: keeps the measured extremes and turns colour commands into gray
// levels with a restoring divider. Depends on htgn_pkg.
module htgn_back #(
  parameter int unsigned HEIGHT_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  htgn_pkg::q_entry_t head_i,
  output logic               pop_o,
  output htgn_pkg::res_t     res_o,
  input  logic               res_take_i
);
  import htgn_pkg::*;

  localparam int unsigned HB = HEIGHT_BITS;
  localparam int unsigned NW = HEIGHT_BITS + 9;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic signed [HB-1:0] low_q, low_d, high_q, high_d;
  logic                 have_q, have_d;
  logic [HB-1:0]        range_q, range_d, off_q, off_d;
  logic                 flat_q, flat_d, clamped_q, clamped_d;
  logic [7:0]           gray_q, gray_d;
  logic [NW-1:0]        rem_q, rem_d, dsh_q, dsh_d, prod_q, prod_d;
  logic [2:0]           cnt_q, cnt_d;

  logic signed [HB-1:0] h;
  logic [HB-1:0]        span, rel;
  logic [HB-1:0]        range_c;
  logic                 below, above, ge;
  logic [NW-1:0]        rx, ox;

  if (HB <= 32) begin : g_narrow
    assign h = head_i.height[HB-1:0];
  end else begin : g_wide
    assign h = {{(HB-32){1'b0}}, head_i.height};
  end

  assign span    = high_q - low_q;
  assign rel     = h - low_q;
  assign range_c = span;
  assign below   = (h < low_q);
  assign above   = (h > high_q);
  assign rx      = {9'b0, range_q};
  assign ox      = {9'b0, off_q};
  assign ge      = (rem_q >= dsh_q);

  assign pop_o       = head_valid_i && (state_q == ST_IDLE);
  assign res_o.valid = (state_q == ST_DONE);
  assign res_o.item  = '{gray: gray_q, flat_or_empty: flat_q, clamped: clamped_q};

  always_comb begin
    state_d   = state_q;
    low_d     = low_q;
    high_d    = high_q;
    have_d    = have_q;
    range_d   = range_q;
    off_d     = off_q;
    flat_d    = flat_q;
    clamped_d = clamped_q;
    gray_d    = gray_q;
    rem_d     = rem_q;
    dsh_d     = dsh_q;
    prod_d    = prod_q;
    cnt_d     = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          unique case (head_i.cmd)
            CMD_RESTART: begin
              low_d  = h;
              high_d = h;
              have_d = 1'b1;
            end
            CMD_MEASURE: begin
              if (!have_q) begin
                low_d  = h;
                high_d = h;
                have_d = 1'b1;
              end else begin
                if (below) low_d = h;
                if (above) high_d = h;
              end
            end
            CMD_COLOUR: begin
              if (!have_q || range_c == '0) begin
                gray_d    = GRAY_BASE;
                flat_d    = 1'b1;
                clamped_d = have_q && (h != low_q);
                state_d   = ST_DONE;
              end else begin
                range_d   = range_c;
                flat_d    = 1'b0;
                clamped_d = below || above;
                off_d     = below ? '0 : (above ? range_c : rel);
                state_d   = ST_MUL;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        rem_d   = (rx << 5) + (rx << 4) + (rx << 1) + rx;
        prod_d  = (ox << 8) + (ox << 7) + (ox << 6) + (ox << 3) + (ox << 1) + ox;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        rem_d   = rem_q + prod_q;
        dsh_d   = {1'b0, range_q, 8'b0};
        cnt_d   = 3'd7;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (ge) rem_d = rem_q - dsh_q;
        gray_d = {gray_q[6:0], ge};
        dsh_d  = dsh_q >> 1;
        cnt_d  = cnt_q - 3'd1;
        if (cnt_q == 3'd0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      low_q   <= '0;
      high_q  <= '0;
      have_q  <= 1'b0;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      low_q   <= low_d;
      high_q  <= high_d;
      have_q  <= have_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    range_q   <= range_d;
    off_q     <= off_d;
    flat_q    <= flat_d;
    clamped_q <= clamped_d;
    gray_q    <= gray_d;
    rem_q     <= rem_d;
    dsh_q     <= dsh_d;
    prod_q    <= prod_d;
  end

endmodule

// File: hw/rtl/height_to_grayscale_normalizer_core.sv
// Top level of the height to gray level normalizer: front queue, back
// datapath and the output register. Depends on htgn_pkg, htgn_front, htgn_back.
//
// Measure items (op 0 restarts the extremes, op 1 extends them) are taken in the
// idle state of the back part and give no result; op 3 is dropped at the input.
// A colour item (op 2) gives one gray level: with a known range the back part
// does range and offset, two constant multiplies, the sum, eight steps of the
// restoring divider and hand-over; with nothing measured or a zero range only the
// hand-over. The eight-step divider loop sets the colour rate. A two-entry
// command queue in front and the output register let either side stall alone.
module height_to_grayscale_normalizer_core #(
  parameter int unsigned HEIGHT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  htgn_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output htgn_pkg::out_item_t out_item_o
);
  import htgn_pkg::*;

  logic      head_valid, pop, take;
  q_entry_t  head;
  res_t      res;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  htgn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  htgn_back #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_o        (res),
    .res_take_i   (take)
  );

  assign take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) out_valid_d = res.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res.valid) begin
      out_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hw/rtl/htgn_checker.sv
// Port-level checks of the normalizer output and their binding to the top.
// Depends on htgn_pkg and the assertion macro header.
`include "height_to_grayscale_normalizer_core_defines.svh"

module htgn_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input htgn_pkg::out_item_t out_item_o
);
  import htgn_pkg::*;

  `HTGN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_item_o))
  `HTGN_ASSERT_NOW(a_flat_gray, clk_i, rst_ni, out_valid_o && out_item_o.flat_or_empty,
                   out_item_o.gray == GRAY_BASE)
  `HTGN_ASSERT_NOW(a_gray_floor, clk_i, rst_ni, out_valid_o,
                   out_item_o.gray >= GRAY_BASE)

endmodule

bind height_to_grayscale_normalizer_core htgn_checker u_htgn_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for height_to_grayscale_normalizer_core: a table of
// directed items, then random measure/colour passes and bursts of random ops
// checked against a predictor. Depends on htgn_pkg and the RTL of the core.
module tb;
  import htgn_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         ITEM_TARGET = 1100;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         LONG_HOLD   = 400;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] height;
    logic        has_want;
    out_item_t   want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  logic      row_has_want = 1'b0;
  out_item_t row_want = '0;

  longint signed pred_low;
  longint signed pred_high;
  bit            pred_have_extent;

  out_item_t gray_expect_q[$];
  dir_row_t  directed_rows [25];
  int        fail_count;
  int        items_sent;
  int        cycle_count;
  bit        src_idle;

  height_to_grayscale_normalizer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0d] %s", cycle_count, what);
    end
  endfunction

  function automatic bit predict_gray(input in_item_t it, output out_item_t res);
    longint signed   h;
    longint unsigned rng;
    longint unsigned off;
    res = '0;
    h = longint'($signed(it.height));
    if (it.op == OP_RESTART || (it.op == OP_MEASURE && !pred_have_extent)) begin
      pred_low = h;
      pred_high = h;
      pred_have_extent = 1'b1;
      return 1'b0;
    end
    if (it.op == OP_MEASURE) begin
      if (h < pred_low) pred_low = h;
      if (h > pred_high) pred_high = h;
      return 1'b0;
    end
    if (it.op != OP_COLOUR) return 1'b0;
    res.gray = GRAY_BASE;
    res.flat_or_empty = 1'b1;
    if (!pred_have_extent) return 1'b1;
    rng = longint'(pred_high - pred_low);
    if (rng == 0) begin
      res.clamped = (h != pred_low);
      return 1'b1;
    end
    res.flat_or_empty = 1'b0;
    if (h < pred_low) begin
      off = 0;
      res.clamped = 1'b1;
    end else if (h > pred_high) begin
      off = rng;
      res.clamped = 1'b1;
    end else begin
      off = longint'(h - pred_low);
    end
    res.gray = 8'((51 * rng + 459 * off) / (2 * rng));
    return 1'b1;
  endfunction

  function automatic void check_gray(input out_item_t got);
    out_item_t want;
    if (gray_expect_q.size() == 0) begin
      note_failure($sformatf("unexpected result gray %0d flat %b clamped %b",
                             got.gray, got.flat_or_empty, got.clamped));
      return;
    end
    want = gray_expect_q.pop_front();
    if (got.gray !== want.gray || got.flat_or_empty !== want.flat_or_empty ||
        got.clamped !== want.clamped) begin
      note_failure($sformatf("gray %0d/%0d flat %b/%b clamped %b/%b (expected/actual)",
                             want.gray, got.gray, want.flat_or_empty,
                             got.flat_or_empty, want.clamped, got.clamped));
    end
  endfunction

  always @(posedge clk_i) begin : handshake_monitor
    out_item_t res;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (predict_gray(in_item_i, res)) begin
          gray_expect_q.push_back(row_has_want ? row_want : res);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        check_gray(out_item_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("height_to_grayscale_normalizer_core regression: fail");
      $finish;
    end
  end

  initial begin : result_sink
    int wait_n;
    int taken;
    bit sink_idle;
    taken = 0;
    sink_idle = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken % 50 == 0) sink_idle = ($urandom_range(0, 2) != 0);
      wait_n = sink_idle ? $urandom_range(0, 8) : 0;
      if (taken == 100) wait_n = LONG_HOLD;
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  task automatic send_item(input logic [1:0] it_op, input logic [31:0] it_height,
                           input logic has_want, input out_item_t want);
    int gap;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{op: it_op, height: it_height};
    row_has_want <= has_want;
    row_want <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (it_op != OP_UNUSED) items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (gray_expect_q.size() != 0);
  endtask

  function automatic logic [31:0] near_height(input logic [31:0] base,
                                              input int unsigned spread);
    return base + ($urandom % (2 * spread + 1)) - spread;
  endfunction

  task automatic send_pass();
    logic [31:0]   base;
    logic [31:0]   h;
    int unsigned   spread;
    int            n_meas;
    int            n_col;
    int            pick;
    longint signed lo;
    longint signed hi;
    longint signed rng;
    case ($urandom_range(0, 5))
      0:       spread = 0;
      1:       spread = 1;
      2:       spread = 16;
      3:       spread = 4096;
      4:       spread = 32'h0010_0000;
      default: spread = 32'h4000_0000;
    endcase
    base = $urandom;
    n_meas = $urandom_range(1, 6);
    n_col = $urandom_range(1, 10);
    lo = 0;
    hi = 0;
    for (int i = 0; i < n_meas; i++) begin
      h = near_height(base, spread);
      if (i == 0) begin
        lo = longint'($signed(h));
        hi = lo;
      end else begin
        if (longint'($signed(h)) < lo) lo = longint'($signed(h));
        if (longint'($signed(h)) > hi) hi = longint'($signed(h));
      end
      send_item((i == 0 && $urandom_range(0, 9) != 0) ? OP_RESTART : OP_MEASURE,
                h, 1'b0, '0);
    end
    rng = hi - lo;
    for (int i = 0; i < n_col; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) h = 32'(lo + (longint'($urandom) % (rng + 1)));
      else if (pick == 6) h = 32'(lo);
      else if (pick == 7) h = 32'(hi);
      else if (pick == 8) h = ($urandom_range(0, 1) != 0) ? 32'(lo - 1) : 32'(hi + 1);
      else h = near_height(base, spread);
      send_item(OP_COLOUR, h, 1'b0, '0);
    end
  endtask

  initial begin : item_source
    bit paused;
    directed_rows = '{
      '{OP_COLOUR,  32'h0000_0000, 1'b1, '{GRAY_BASE, 1'b1, 1'b0}},
      '{OP_UNUSED,  32'hFFFF_FFFF, 1'b0, '0},
      '{OP_COLOUR,  32'h7FFF_FFFF, 1'b1, '{GRAY_BASE, 1'b1, 1'b0}},
      '{OP_MEASURE, 32'd100,       1'b0, '0},
      '{OP_COLOUR,  32'd100,       1'b1, '{GRAY_BASE, 1'b1, 1'b0}},
      '{OP_COLOUR,  32'd101,       1'b1, '{GRAY_BASE, 1'b1, 1'b1}},
      '{OP_COLOUR,  32'hFFFF_FFFB, 1'b1, '{GRAY_BASE, 1'b1, 1'b1}},
      '{OP_RESTART, 32'h8000_0000, 1'b0, '0},
      '{OP_MEASURE, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_MEASURE, 32'h0000_0000, 1'b0, '0},
      '{OP_COLOUR,  32'h8000_0000, 1'b1, '{GRAY_BASE, 1'b0, 1'b0}},
      '{OP_COLOUR,  32'h7FFF_FFFF, 1'b1, '{8'd255, 1'b0, 1'b0}},
      '{OP_COLOUR,  32'h0000_0000, 1'b0, '0},
      '{OP_COLOUR,  32'h5555_5555, 1'b0, '0},
      '{OP_UNUSED,  32'h0000_0000, 1'b0, '0},
      '{OP_RESTART, 32'hFFFF_FC18, 1'b0, '0},
      '{OP_MEASURE, 32'd1000,      1'b0, '0},
      '{OP_COLOUR,  32'hFFFF_EC78, 1'b1, '{GRAY_BASE, 1'b0, 1'b1}},
      '{OP_COLOUR,  32'd5000,      1'b1, '{8'd255, 1'b0, 1'b1}},
      '{OP_COLOUR,  32'd0,         1'b1, '{8'd140, 1'b0, 1'b0}},
      '{OP_RESTART, 32'd7,         1'b0, '0},
      '{OP_MEASURE, 32'd8,         1'b0, '0},
      '{OP_COLOUR,  32'd7,         1'b1, '{GRAY_BASE, 1'b0, 1'b0}},
      '{OP_COLOUR,  32'd8,         1'b1, '{8'd255, 1'b0, 1'b0}},
      '{OP_COLOUR,  32'hAAAA_AAAA, 1'b0, '0}
    };
    pred_low = 0;
    pred_high = 0;
    pred_have_extent = 1'b0;
    paused = 1'b0;
    src_idle = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].height,
                directed_rows[i].has_want, directed_rows[i].want);
    end
    drain_results();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 15) == 0) src_idle = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(2'($urandom_range(0, 3)), $urandom, 1'b0, '0);
        end
      end else begin
        send_pass();
      end
      if (!paused && items_sent >= ITEM_TARGET / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    in_valid_i <= 1'b0;
    while (gray_expect_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (gray_expect_q.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", gray_expect_q.size()));
    end
    if (fail_count == 0) begin
      $display("height_to_grayscale_normalizer_core regression: pass");
    end else begin
      $display("height_to_grayscale_normalizer_core regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/htgn_pkg.sv
hw/rtl/htgn_front.sv
hw/rtl/htgn_back.sv
hw/rtl/height_to_grayscale_normalizer_core.sv
hw/rtl/htgn_checker.sv
dv/tb.sv
